/* src/m4ct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4ct_pkg
// Shared types and default constants for the 4x4 column transform core.
// ----------------------------------------------------------------------------
package m4ct_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int DIM        = 4;
    localparam int ELEM_COUNT = DIM * DIM;
    localparam int INDEX_W    = 4;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_XFORM = 1'b1
    } t_cmd;

endpackage

/* src/matrix4_column_transform_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_column_transform_core
// 4x4 signed fixed point matrix times column, with element load items.
// ----------------------------------------------------------------------------
// usage:
//   slave channel (i_s_*) takes items; tuser is the command: 0 loads one
//   matrix element (index = row + 4 * column), 1 transforms a column
//   vector by the stored matrix.
//   master channel (o_m_*) returns one item per transform: the four row
//   results, saturated, and a flag in tuser if any row saturated.
//   load items return nothing.
// path: a transform item passes through a queue slot, the product register
//   and the sum/saturate output register before its result is valid.
// throughput: one item per cycle while the output is not stalled, set by the
//   sixteen parallel multipliers in the product stage; loads also drain one per cycle.
// reset: the matrix returns to identity, the queue and pipeline empty,
//   and o_s_tready is high from the first cycle after reset.
// stall: when i_m_tready is low the output item holds; the product stage
//   and the input queue fill in turn, then o_s_tready drops. a load at the
//   head of the queue keeps draining while the output is stalled.
// ----------------------------------------------------------------------------
module matrix4_column_transform_core
    import m4ct_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int IN_BITS     = INDEX_W + (DIM + 1) * VALUE_WIDTH,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = DIM * VALUE_WIDTH,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // cmd
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // res_x, res_y, res_z, res_w, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // sat_flag
    output logic                   o_m_tuser
);

    logic                            w_q_valid;
    logic                            w_q_pop;
    t_cmd                            w_q_cmd;
    logic [INDEX_W-1:0]              w_q_index;
    logic [VALUE_WIDTH-1:0]          w_q_value;
    logic [DIM-1:0][VALUE_WIDTH-1:0] w_q_vec;
    logic [DIM-1:0][VALUE_WIDTH-1:0] w_res;

    m4ct_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IN_TDATA_W  (IN_TDATA_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_cmd    (w_q_cmd),
        .o_q_index  (w_q_index),
        .o_q_value  (w_q_value),
        .o_q_vec    (w_q_vec)
    );

    m4ct_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_cmd     (w_q_cmd),
        .i_q_index   (w_q_index),
        .i_q_value   (w_q_value),
        .i_q_vec     (w_q_vec),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (w_res),
        .o_sat       (o_m_tuser)
    );

    assign o_m_tdata = OUT_TDATA_W'(w_res);

endmodule

/* src/m4ct_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4ct_front
// Input side: unpacks stream items, tags write or transform, and holds them
// in a short queue until the compute side takes them.
// ----------------------------------------------------------------------------
module m4ct_front
    import m4ct_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int IN_TDATA_W  = 168
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, zero pad
    input  logic [IN_TDATA_W-1:0]           i_s_tdata,
    // cmd
    input  logic                            i_s_tuser,
    output logic                            o_q_valid,
    input  logic                            i_q_pop,
    output t_cmd                            o_q_cmd,
    output logic [INDEX_W-1:0]              o_q_index,
    output logic [VALUE_WIDTH-1:0]          o_q_value,
    output logic [DIM-1:0][VALUE_WIDTH-1:0] o_q_vec
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int VAL_LO = INDEX_W;
    localparam int VEC_LO = INDEX_W + VALUE_WIDTH;

    t_cmd                            r_cmd   [QUEUE_DEPTH];
    logic [INDEX_W-1:0]              r_index [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0]          r_value [QUEUE_DEPTH];
    logic [DIM-1:0][VALUE_WIDTH-1:0] r_vec   [QUEUE_DEPTH];

    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic w_push;
    logic w_pop;
    logic [DIM-1:0][VALUE_WIDTH-1:0] w_in_vec;

    assign o_s_tready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_q_pop && o_q_valid;

    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            w_in_vec[c] = i_s_tdata[VEC_LO + c*VALUE_WIDTH +: VALUE_WIDTH];
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_cmd[r_wr_ptr]   <= t_cmd'(i_s_tuser);
            r_index[r_wr_ptr] <= i_s_tdata[INDEX_W-1:0];
            r_value[r_wr_ptr] <= i_s_tdata[VAL_LO +: VALUE_WIDTH];
            r_vec[r_wr_ptr]   <= w_in_vec;
        end
    end

    assign o_q_cmd   = r_cmd[r_rd_ptr];
    assign o_q_index = r_index[r_rd_ptr];
    assign o_q_value = r_value[r_rd_ptr];
    assign o_q_vec   = r_vec[r_rd_ptr];

endmodule

/* src/m4ct_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4ct_back
// Compute side: owns the matrix, applies element writes in order, and runs
// transforms through a product stage and a sum/saturate output stage.
// ----------------------------------------------------------------------------
module m4ct_back
    import m4ct_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  t_cmd                            i_q_cmd,
    input  logic [INDEX_W-1:0]              i_q_index,
    input  logic [VALUE_WIDTH-1:0]          i_q_value,
    input  logic [DIM-1:0][VALUE_WIDTH-1:0] i_q_vec,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic [DIM-1:0][VALUE_WIDTH-1:0] o_res,
    output logic                            o_sat
);

    localparam int FULL_W = 2 * VALUE_WIDTH;
    localparam int PROD_W = FULL_W - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int HI_W   = SUM_W - VALUE_WIDTH + 1;

    localparam logic [VALUE_WIDTH-1:0] ONE     = VALUE_WIDTH'(1) << FRAC_BITS;
    localparam logic [VALUE_WIDTH-1:0] MAX_VAL = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [VALUE_WIDTH-1:0] r_mat [ELEM_COUNT];

    logic signed [PROD_W-1:0] r_prod [DIM][DIM];
    logic                     r_s1_valid;

    logic [DIM-1:0][VALUE_WIDTH-1:0] r_res;
    logic                            r_sat;
    logic                            r_out_valid;

    logic signed [FULL_W-1:0] w_full [DIM][DIM];
    logic signed [SUM_W-1:0]  w_sum  [DIM];
    logic [DIM-1:0][VALUE_WIDTH-1:0] w_res;
    logic [DIM-1:0]           w_row_sat;
    logic [HI_W-1:0]          w_hi   [DIM];

    logic w_advance;
    logic w_s1_ready;
    logic w_is_write;

    assign w_advance  = !r_out_valid || i_res_ready;
    assign w_s1_ready = !r_s1_valid || w_advance;
    assign w_is_write = (i_q_cmd == CMD_WRITE);
    // writes never occupy the product stage, so they drain even when stalled
    assign o_q_pop    = i_q_valid && (w_is_write || w_s1_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ELEM_COUNT; i++) begin
                r_mat[i] <= (i % 5 == 0) ? ONE : '0;
            end
        end else if (o_q_pop && w_is_write) begin
            r_mat[i_q_index] <= i_q_value;
        end
    end

    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                w_full[r][c] = $signed(r_mat[r + DIM*c]) * $signed(i_q_vec[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= o_q_pop && !w_is_write;
        end
    end

    // product truncated toward minus infinity
    always_ff @(posedge i_clk) begin
        if (w_s1_ready && o_q_pop && !w_is_write) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_prod[r][c] <= PROD_W'(w_full[r][c] >>> FRAC_BITS);
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            w_sum[r] = '0;
            for (int c = 0; c < DIM; c++) begin
                w_sum[r] = w_sum[r] + SUM_W'(r_prod[r][c]);
            end
            w_hi[r] = w_sum[r][SUM_W-1:VALUE_WIDTH-1];
            // in range when the top bits are all copies of the sign
            w_row_sat[r] = !((&w_hi[r]) || !(|w_hi[r]));
            if (!w_row_sat[r]) begin
                w_res[r] = w_sum[r][VALUE_WIDTH-1:0];
            end else if (w_sum[r][SUM_W-1]) begin
                w_res[r] = MIN_VAL;
            end else begin
                w_res[r] = MAX_VAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_res <= w_res;
            r_sat <= |w_row_sat;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;
    assign o_sat       = r_sat;

endmodule

/* src/m4ct_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4ct_checker
// Port-level checks for the column transform core, bound to the top level.
// ----------------------------------------------------------------------------
module m4ct_checker
    import m4ct_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int OUT_TDATA_W = 128
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tuser
);

    localparam logic [VALUE_WIDTH-1:0] MAX_VAL = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [VALUE_WIDTH-1:0] w_rx, w_ry, w_rz, w_rw;

    assign w_rx = o_m_tdata[0*VALUE_WIDTH +: VALUE_WIDTH];
    assign w_ry = o_m_tdata[1*VALUE_WIDTH +: VALUE_WIDTH];
    assign w_rz = o_m_tdata[2*VALUE_WIDTH +: VALUE_WIDTH];
    assign w_rw = o_m_tdata[3*VALUE_WIDTH +: VALUE_WIDTH];

    // nothing is in flight right after reset
    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output item changed");

    // a flagged item must carry at least one clamped row
    a_sat_has_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            w_rx == MAX_VAL || w_rx == MIN_VAL || w_ry == MAX_VAL || w_ry == MIN_VAL ||
            w_rz == MAX_VAL || w_rz == MIN_VAL || w_rw == MAX_VAL || w_rw == MIN_VAL)
        else $error("saturation flag without a clamped row");

endmodule

bind matrix4_column_transform_core m4ct_checker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .OUT_TDATA_W (OUT_TDATA_W)
) u_m4ct_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

/* sim/tb_matrix4_column_transform_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4_column_transform_core
// Self-checking bench for the 4x4 column transform core. Load and transform
// items go in through the slave stream in random bursts, and the master side
// stalls on its own pattern. A shadow copy of the matrix predicts each
// saturated Q16.16 result, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_matrix4_column_transform_core;
    import m4ct_pkg::*;

    localparam int VW         = VALUE_WIDTH_DEF;
    localparam int FB         = FRAC_BITS_DEF;
    localparam int IN_TDATA_W = ((INDEX_W + (DIM + 1) * VW + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DIM * VW + 7) / 8) * 8;
    localparam int ITEM_TARGET = 1700;

    localparam logic [VW-1:0] Q_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] Q_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] Q_ONE = 1 << FB;

    typedef struct packed {
        t_cmd                  cmd;
        logic [INDEX_W-1:0]    idx;
        logic [VW-1:0]         val;
        logic [VW-1:0]         vx;
        logic [VW-1:0]         vy;
        logic [VW-1:0]         vz;
        logic [VW-1:0]         vw;
    } t_col_item;

    typedef struct packed {
        logic [VW-1:0] rx;
        logic [VW-1:0] ry;
        logic [VW-1:0] rz;
        logic [VW-1:0] rw;
        logic          sat;
    } t_col_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, zero pad
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    // cmd
    logic                   i_s_tuser = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b1;
    // res_x, res_y, res_z, res_w, zero pad
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // sat_flag
    logic                   o_m_tuser;

    t_col_item   pending_items[$];
    t_col_result expected_columns[$];
    logic [VW-1:0] shadow_matrix [ELEM_COUNT];

    t_col_item   cur_item;
    t_col_result want;
    int          mismatches = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;

    matrix4_column_transform_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // stored matrix times one column: truncated products, exact row sums,
    // saturation of each row to the value width
    function automatic t_col_result transform_column(input t_col_item it);
        logic signed [VW-1:0]   vec [DIM];
        logic [VW-1:0]          row_out [DIM];
        logic signed [2*VW-1:0] prod;
        logic signed [2*VW-1:0] shifted;
        logic signed [2*VW+1:0] acc;
        logic                   sat;
        t_col_result            res;
        vec[0] = it.vx;
        vec[1] = it.vy;
        vec[2] = it.vz;
        vec[3] = it.vw;
        sat = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            acc = '0;
            for (int c = 0; c < DIM; c++) begin
                prod = $signed(shadow_matrix[r + DIM * c]) * vec[c];
                shifted = prod >>> FB;
                acc = acc + shifted;
            end
            if (acc[2*VW+1:VW-1] != {(VW+3){acc[2*VW+1]}}) begin
                sat = 1'b1;
                row_out[r] = acc[2*VW+1] ? Q_MIN : Q_MAX;
            end else begin
                row_out[r] = acc[VW-1:0];
            end
        end
        res.rx = row_out[0];
        res.ry = row_out[1];
        res.rz = row_out[2];
        res.rw = row_out[3];
        res.sat = sat;
        return res;
    endfunction

    task automatic add_item(input t_cmd cmd, input logic [INDEX_W-1:0] idx,
                            input logic [VW-1:0] val, input logic [VW-1:0] vx,
                            input logic [VW-1:0] vy, input logic [VW-1:0] vz,
                            input logic [VW-1:0] vw);
        t_col_item it;
        it.cmd = cmd;
        it.idx = idx;
        it.val = val;
        it.vx = vx;
        it.vy = vy;
        it.vz = vz;
        it.vw = vw;
        pending_items.push_back(it);
    endtask

    // half modest Q16.16 values, some extremes, some fully random words
    function automatic logic [VW-1:0] rand_q16();
        int unsigned sel;
        logic [VW-1:0] v;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 5))
                0: v = Q_MAX;
                1: v = Q_MIN;
                2: v = '0;
                3: v = '1;
                4: v = 1;
                default: v = Q_ONE;
            endcase
        end else if (sel <= 5) begin
            v = $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (cur_item.cmd == CMD_WRITE)
                    shadow_matrix[cur_item.idx] = cur_item.val;
                else
                    expected_columns.push_back(transform_column(cur_item));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    i_s_tdata <= {{(IN_TDATA_W - INDEX_W - 5 * VW){1'b0}},
                                  cur_item.vw, cur_item.vz, cur_item.vy,
                                  cur_item.vx, cur_item.val, cur_item.idx};
                    i_s_tuser <= cur_item.cmd;
                    i_s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(20, 80) : $urandom_range(1, 6);
                        gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: segments of always ready, random, sparse and full stall
    always @(posedge i_clk) begin
        if (stall_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(2, 24) : $urandom_range(10, 120);
        end
        stall_left--;
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= $urandom_range(0, 1);
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_columns.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: tdata=%h tuser=%b",
                             o_m_tdata, o_m_tuser);
            end else begin
                want = expected_columns.pop_front();
                if (o_m_tdata[VW-1:0] !== want.rx || o_m_tdata[2*VW-1:VW] !== want.ry ||
                    o_m_tdata[3*VW-1:2*VW] !== want.rz ||
                    o_m_tdata[4*VW-1:3*VW] !== want.rw || o_m_tuser !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp x=%h y=%h z=%h w=%h sat=%b,",
                                 want.rx, want.ry, want.rz, want.rw, want.sat,
                                 " got x=%h y=%h z=%h w=%h sat=%b",
                                 o_m_tdata[VW-1:0], o_m_tdata[2*VW-1:VW],
                                 o_m_tdata[3*VW-1:2*VW], o_m_tdata[4*VW-1:3*VW],
                                 o_m_tuser);
                end
            end
        end
    end

    initial begin
        int unsigned start;
        int unsigned step;
        int unsigned kind;
        int unsigned n;
        for (int i = 0; i < ELEM_COUNT; i++)
            shadow_matrix[i] = (i % 5 == 0) ? Q_ONE : '0;

        // directed: identity pass-through, saturation both ways, rounding
        add_item(CMD_XFORM, 4'hf, Q_MAX, Q_ONE, 32'hfffd_0000, Q_MAX, Q_MIN);
        add_item(CMD_XFORM, 4'h0, '0, '0, '0, '0, '0);
        add_item(CMD_XFORM, 4'h5, '1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        add_item(CMD_WRITE, 4'h0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_item(CMD_WRITE, 4'h4, Q_MAX, '1, '1, '1, '1);
        add_item(CMD_XFORM, 4'h0, Q_MIN, Q_MAX, Q_MAX, '0, '0);
        add_item(CMD_WRITE, 4'h8, Q_MIN, '0, '0, '0, '0);
        add_item(CMD_WRITE, 4'hc, Q_MIN, $urandom, $urandom, $urandom, $urandom);
        add_item(CMD_XFORM, 4'h3, $urandom, Q_MIN, Q_MAX, Q_MIN, Q_MIN);
        add_item(CMD_XFORM, 4'h9, $urandom, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        // minus one lsb times one lsb truncates toward minus infinity
        add_item(CMD_WRITE, 4'h5, '1, '0, '0, '0, '0);
        add_item(CMD_XFORM, 4'h0, '0, '0, 1, '0, '0);
        add_item(CMD_XFORM, 4'h0, '0, 1, 1, 1, 1);
        add_item(CMD_WRITE, 4'hf, '0, '0, '0, '0, '0);
        add_item(CMD_WRITE, 4'ha, Q_MIN, '0, '0, '0, '0);
        add_item(CMD_XFORM, 4'h0, '0, 32'hffff_8000, 32'h0000_8000, Q_MIN, Q_MAX);
        add_item(CMD_XFORM, 4'h0, '0, rand_q16(), rand_q16(), rand_q16(), rand_q16());

        while (pending_items.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                // whole matrix load in a shuffled order, then a few columns
                start = $urandom_range(0, 15);
                step = 2 * $urandom_range(0, 7) + 1;
                for (int i = 0; i < ELEM_COUNT; i++)
                    add_item(CMD_WRITE, INDEX_W'((start + i * step) % ELEM_COUNT),
                             rand_q16(), $urandom, $urandom, $urandom, $urandom);
                n = $urandom_range(4, 8);
                for (int i = 0; i < n; i++)
                    add_item(CMD_XFORM, INDEX_W'($urandom), $urandom,
                             rand_q16(), rand_q16(), rand_q16(), rand_q16());
            end else if (kind < 8) begin
                add_item(CMD_WRITE, INDEX_W'($urandom), rand_q16(),
                         $urandom, $urandom, $urandom, $urandom);
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    add_item(CMD_XFORM, INDEX_W'($urandom), $urandom,
                             rand_q16(), rand_q16(), rand_q16(), rand_q16());
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    add_item(t_cmd'($urandom_range(0, 1)), INDEX_W'($urandom), $urandom,
                             $urandom, $urandom, $urandom, $urandom);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_columns.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
